### src/stc_pkg.sv
// Shared types and constants for the settable time-of-day clock.
package stc_pkg;

    // Decoded key codes
    typedef enum logic [1:0] {
        KEY_NONE  = 2'd0,
        KEY_PLUS  = 2'd1,
        KEY_MINUS = 2'd2,
        KEY_LONG  = 2'd3
    } t_key;

    // Display mode
    typedef enum logic [1:0] {
        MODE_RUN         = 2'd0,
        MODE_SET_HOURS   = 2'd1,
        MODE_SET_MINUTES = 2'd2
    } t_mode;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd500;
    localparam logic [4:0]  HOUR_MAX          = 5'd23;
    localparam logic [5:0]  MINUTE_MAX        = 6'd59;
    localparam logic [5:0]  SECOND_MAX        = 6'd59;

    // Time and mode after one update
    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       colon_on;
        t_mode      set_mode;
    } t_stc_result;

endpackage

### src/stc_if.sv
// Valid/ready channel interfaces for key/tick input and time output.
interface stc_in_if #(
    parameter int TICK_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           key_event;
    logic [TICK_BITS-1:0] tick_now;

    modport source (output valid, output key_event, output tick_now, input ready);
    modport sink   (input valid, input key_event, input tick_now, output ready);
endinterface

interface stc_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       colon_on;
    logic [1:0] set_mode;
    logic       hours_blink;
    logic       minutes_blink;

    modport source (output valid, output hours, output minutes, output seconds,
                    output colon_on, output set_mode, output hours_blink,
                    output minutes_blink, input ready);
    modport sink   (input valid, input hours, input minutes, input seconds,
                    input colon_on, input set_mode, input hours_blink,
                    input minutes_blink, output ready);
endinterface

### src/stc_time_core.sv
// Time-of-day state registers and the single-pass update logic.
module stc_time_core #(
    parameter int TICK_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [1:0]           i_key,
    input  logic [TICK_BITS-1:0] i_tick,
    input  logic [15:0]          i_half_period,
    output stc_pkg::t_stc_result o_next
);
    import stc_pkg::*;

    localparam int CMP_W = (TICK_BITS > 16) ? TICK_BITS : 16;

    t_mode                r_mode, n_mode;
    logic [4:0]           r_hour, n_hour;
    logic [5:0]           r_min, n_min;
    logic [5:0]           r_sec, n_sec;
    logic                 r_colon, n_colon;
    logic [TICK_BITS-1:0] r_last, n_last;

    t_key                 w_key;
    logic [TICK_BITS-1:0] w_dist;
    logic [CMP_W-1:0]     w_dist_ext;
    logic [CMP_W-1:0]     w_half_ext;
    logic                 w_toggle;

    assign w_key      = t_key'(i_key);
    assign w_dist     = i_tick - r_last;
    assign w_dist_ext = CMP_W'(w_dist);
    assign w_half_ext = CMP_W'(i_half_period);
    assign w_toggle   = (w_dist_ext >= w_half_ext);

    // Mode next state: long press steps run -> hours -> minutes -> run
    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            MODE_RUN: begin
                if (w_key == KEY_LONG) n_mode = MODE_SET_HOURS;
            end
            MODE_SET_HOURS: begin
                if (w_key == KEY_LONG) n_mode = MODE_SET_MINUTES;
            end
            MODE_SET_MINUTES: begin
                if (w_key == KEY_LONG) n_mode = MODE_RUN;
            end
            default: n_mode = r_mode;
        endcase
    end

    // Time, colon and tick record for the current mode
    always_comb begin
        n_hour  = r_hour;
        n_min   = r_min;
        n_sec   = r_sec;
        n_colon = r_colon;
        n_last  = r_last;
        unique case (r_mode)
            MODE_RUN: begin
                if (w_key == KEY_LONG) begin
                    n_sec = '0;
                end else if (w_toggle) begin
                    n_last  = i_tick;
                    n_colon = ~r_colon;
                    // seconds advance when the colon turns on
                    if (!r_colon) begin
                        if (r_sec >= SECOND_MAX) begin
                            n_sec = '0;
                            if (r_min >= MINUTE_MAX) begin
                                n_min  = '0;
                                n_hour = (r_hour >= HOUR_MAX) ? '0 : r_hour + 5'd1;
                            end else begin
                                n_min = r_min + 6'd1;
                            end
                        end else begin
                            n_sec = r_sec + 6'd1;
                        end
                    end
                end
            end
            MODE_SET_HOURS: begin
                if (w_key == KEY_PLUS && r_hour < HOUR_MAX) begin
                    n_hour = r_hour + 5'd1;
                end else if (w_key == KEY_MINUS && r_hour != '0) begin
                    n_hour = r_hour - 5'd1;
                end
            end
            MODE_SET_MINUTES: begin
                if (w_key == KEY_PLUS && r_min < MINUTE_MAX) begin
                    n_min = r_min + 6'd1;
                end else if (w_key == KEY_MINUS && r_min != '0) begin
                    n_min = r_min - 6'd1;
                end
            end
            default: begin
                n_hour = r_hour;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_RUN;
            r_hour  <= '0;
            r_min   <= '0;
            r_sec   <= '0;
            r_colon <= 1'b0;
            r_last  <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_hour  <= n_hour;
            r_min   <= n_min;
            r_sec   <= n_sec;
            r_colon <= n_colon;
            r_last  <= n_last;
        end
    end

    // Result shows the state after the update
    always_comb begin
        o_next.hours    = n_hour;
        o_next.minutes  = n_min;
        o_next.seconds  = n_sec;
        o_next.colon_on = n_colon;
        o_next.set_mode = n_mode;
    end

`ifndef SYNTHESIS
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hour <= HOUR_MAX && r_min <= MINUTE_MAX && r_sec <= SECOND_MAX)
        else $error("time counter out of range");

    a_colon_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_mode != MODE_RUN) |=> ($stable(r_colon) && $stable(r_last)))
        else $error("colon or tick record moved while setting");

    a_enter_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_mode == MODE_RUN && w_key == KEY_LONG)
        |=> (r_sec == '0 && r_mode == MODE_SET_HOURS && $stable(r_colon)))
        else $error("long press in run mode did not enter hour setting");
`endif

endmodule

### src/settable_time_of_day_clock.sv
// Top level: configuration register, input register, update core, result register.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+---------------------------------------------
//  i_in     | in  | valid / ready  | key_event[1:0], tick_now[TICK_BITS-1:0]
//  o_out    | out | valid / ready  | hours, minutes, seconds, colon_on, set_mode,
//           |     |                | hours_blink, minutes_blink
//  cfg      | in  | i_cfg_we       | i_cfg_wdata[15:0] = half_period_ticks
//
// One transaction per cycle sustained while o_out.ready stays high; a transaction
// passes the input register, then the update logic, then the result register.
// Reset (synchronous, active low) clears the time, mode, colon and tick record and
// loads the half period with 500.
// While o_out.ready is low the result register holds; the input register takes one
// more transaction, then i_in.ready drops until the result is taken.
module settable_time_of_day_clock #(
    parameter int TICK_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    stc_in_if.sink      i_in,
    stc_out_if.source   o_out
);
    import stc_pkg::*;

    logic [15:0]          r_half_period;
    logic                 r_in_valid;
    logic [1:0]           r_in_key;
    logic [TICK_BITS-1:0] r_in_tick;
    logic                 r_out_valid;
    t_stc_result          r_out;
    t_stc_result          w_next;
    logic                 w_advance;

    // Move the held transaction through the update when the result slot frees up
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_half_period <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_key  <= i_in.key_event;
            r_in_tick <= i_in.tick_now;
        end
    end

    stc_time_core #(
        .TICK_BITS (TICK_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_advance),
        .i_key         (r_in_key),
        .i_tick        (r_in_tick),
        .i_half_period (r_half_period),
        .o_next        (w_next)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_next;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.hours         = r_out.hours;
    assign o_out.minutes       = r_out.minutes;
    assign o_out.seconds       = r_out.seconds;
    assign o_out.colon_on      = r_out.colon_on;
    assign o_out.set_mode      = r_out.set_mode;
    assign o_out.hours_blink   = (r_out.set_mode == MODE_SET_HOURS);
    assign o_out.minutes_blink = (r_out.set_mode == MODE_SET_MINUTES);

`ifndef SYNTHESIS
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_key) && $stable(r_in_tick)))
        else $error("held input transaction was overwritten");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result was lost or changed");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("update did not produce a result");
`endif

endmodule

### dv/tb_settable_time_of_day_clock.sv
// Self-checking testbench for the settable time-of-day clock: random key/tick traffic, predicted display.
`timescale 1ns / 100ps

module tb_settable_time_of_day_clock;
    import stc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 40;

    // One key/tick transaction waiting to be driven
    typedef struct {
        t_key        key;
        logic [15:0] tick;
    } t_key_tick;

    // Display state the block should show after one transaction
    typedef struct {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic       colon_on;
        t_mode      set_mode;
        logic       hours_blink;
        logic       minutes_blink;
    } t_display;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    stc_in_if #(.TICK_BITS(16)) in_if ();
    stc_out_if                  out_if ();

    settable_time_of_day_clock #(
        .TICK_BITS(16)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    t_key_tick   key_tick_q[$];
    t_display    expected_display_q[$];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    logic [15:0] tick_cursor    = 16'd0;

    // Predicted clock state
    logic [15:0] clk_half_period = HALF_PERIOD_RESET;
    logic [5:0]  clk_sec         = 6'd0;
    logic [5:0]  clk_min         = 6'd0;
    logic [4:0]  clk_hr          = 5'd0;
    t_mode       clk_mode        = MODE_RUN;
    logic        clk_colon       = 1'b0;
    logic [15:0] clk_last_tick   = 16'd0;

    // Idle lengths for both sides
    int in_gap    = 0;
    int in_quiet  = 0;
    int out_stall = 0;
    int out_quiet = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mostly short idles, a few long ones, and now and then a stretch with none
    function automatic int idle_len(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) quiet = $urandom_range(20, 80);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Advance the predicted clock by one transaction and return the display
    function automatic t_display predict_display(t_key key, logic [15:0] now);
        logic [15:0] tick_gap;
        t_display    d;
        if (clk_mode == MODE_RUN && key != KEY_LONG) begin
            tick_gap = now - clk_last_tick;
            if (tick_gap >= clk_half_period) begin
                clk_last_tick = now;
                clk_colon     = ~clk_colon;
                // seconds advance on the rising colon only
                if (clk_colon) begin
                    if (clk_sec == SECOND_MAX) begin
                        clk_sec = 6'd0;
                        if (clk_min == MINUTE_MAX) begin
                            clk_min = 6'd0;
                            clk_hr  = (clk_hr == HOUR_MAX) ? 5'd0 : clk_hr + 5'd1;
                        end else begin
                            clk_min = clk_min + 6'd1;
                        end
                    end else begin
                        clk_sec = clk_sec + 6'd1;
                    end
                end
            end
        end else begin
            case (clk_mode)
                MODE_RUN: begin
                    clk_sec  = 6'd0;
                    clk_mode = MODE_SET_HOURS;
                end
                MODE_SET_HOURS: begin
                    case (key)
                        KEY_PLUS:  if (clk_hr < HOUR_MAX) clk_hr = clk_hr + 5'd1;
                        KEY_MINUS: if (clk_hr != 5'd0) clk_hr = clk_hr - 5'd1;
                        KEY_LONG:  clk_mode = MODE_SET_MINUTES;
                        default: ;
                    endcase
                end
                MODE_SET_MINUTES: begin
                    case (key)
                        KEY_PLUS:  if (clk_min < MINUTE_MAX) clk_min = clk_min + 6'd1;
                        KEY_MINUS: if (clk_min != 6'd0) clk_min = clk_min - 6'd1;
                        KEY_LONG:  clk_mode = MODE_RUN;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        d.hours         = clk_hr;
        d.minutes       = clk_min;
        d.seconds       = clk_sec;
        d.colon_on      = clk_colon;
        d.set_mode      = clk_mode;
        d.hours_blink   = (clk_mode == MODE_SET_HOURS);
        d.minutes_blink = (clk_mode == MODE_SET_MINUTES);
        return d;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic push_item(t_key key, logic [15:0] tick);
        t_key_tick it;
        it.key  = key;
        it.tick = tick;
        key_tick_q.push_back(it);
    endtask

    // Next running tick: exact half period, one short, anything up to it, or anywhere
    function automatic logic [15:0] advance_tick(logic [15:0] hp);
        int          r;
        logic [15:0] step;
        r = $urandom_range(0, 99);
        if (r < 30)      step = hp;
        else if (r < 40) step = hp - 16'd1;
        else if (r < 90) step = 16'($urandom_range(0, hp));
        else             step = 16'($urandom_range(0, 65535));
        tick_cursor = tick_cursor + step;
        return tick_cursor;
    endfunction

    function automatic t_key set_key(int up_pct);
        if ($urandom_range(0, 99) < 8) return KEY_NONE;
        return ($urandom_range(0, 99) < up_pct) ? KEY_PLUS : KEY_MINUS;
    endfunction

    // Set 23:59 and run until the day rolls over
    task automatic push_rollover(logic [15:0] hp);
        push_item(KEY_LONG, 16'($urandom_range(0, 65535)));
        repeat (25) push_item(KEY_PLUS, 16'($urandom_range(0, 65535)));
        push_item(KEY_LONG, 16'($urandom_range(0, 65535)));
        repeat (62) push_item(KEY_PLUS, 16'($urandom_range(0, 65535)));
        push_item(KEY_LONG, 16'($urandom_range(0, 65535)));
        repeat (130) begin
            tick_cursor = tick_cursor + hp;
            push_item(KEY_NONE, tick_cursor);
        end
    endtask

    // Mix of full set sequences, running bursts and stray keys
    task automatic gen_traffic(int n_items, logic [15:0] hp);
        int made;
        int r;
        int len;
        int up_pct;
        t_key k;
        made = 0;
        while (made < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                case ($urandom_range(0, 2))
                    0:       up_pct = 90;
                    1:       up_pct = 10;
                    default: up_pct = 50;
                endcase
                push_item(KEY_LONG, 16'($urandom_range(0, 65535)));
                len = $urandom_range(0, 30);
                repeat (len) push_item(set_key(up_pct), 16'($urandom_range(0, 65535)));
                made += len + 1;
                push_item(KEY_LONG, 16'($urandom_range(0, 65535)));
                len = $urandom_range(0, 70);
                repeat (len) push_item(set_key(up_pct), 16'($urandom_range(0, 65535)));
                push_item(KEY_LONG, 16'($urandom_range(0, 65535)));
                made += len + 2;
            end else if (r < 88) begin
                len = $urandom_range(1, 20);
                repeat (len) begin
                    r = $urandom_range(0, 99);
                    k = (r < 85) ? KEY_NONE : ((r < 93) ? KEY_PLUS : KEY_MINUS);
                    push_item(k, advance_tick(hp));
                end
                made += len;
            end else begin
                tick_cursor = 16'($urandom_range(0, 65535));
                push_item(t_key'($urandom_range(0, 3)), tick_cursor);
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        while (key_tick_q.size() != 0 || in_if.valid || expected_display_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Half period write, only once the block has settled
    task automatic write_half_period(logic [15:0] value);
        wait_drained();
        repeat (3) @(posedge i_clk);
        i_cfg_we        <= 1'b1;
        i_cfg_wdata     <= value;
        clk_half_period  = value;
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
    endtask

    // Driver: present queued key/tick transactions, predict each accepted one
    always @(posedge i_clk) begin
        t_key_tick it;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready)
                expected_display_q.push_back(predict_display(t_key'(in_if.key_event),
                                                             in_if.tick_now));
            if (!in_if.valid || in_if.ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_if.valid <= 1'b0;
                end else if (key_tick_q.size() > 0) begin
                    it = key_tick_q.pop_front();
                    in_if.valid     <= 1'b1;
                    in_if.key_event <= it.key;
                    in_if.tick_now  <= it.tick;
                    in_gap = idle_len(in_quiet);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, compare each result with the oldest prediction
    always @(posedge i_clk) begin
        t_display want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_display_q.size() == 0) begin
                    report_mismatch("result with nothing expected, hours",
                                    16'(out_if.hours), 16'd0);
                end else begin
                    want = expected_display_q.pop_front();
                    if (out_if.hours !== want.hours)
                        report_mismatch("hours", 16'(out_if.hours), 16'(want.hours));
                    if (out_if.minutes !== want.minutes)
                        report_mismatch("minutes", 16'(out_if.minutes), 16'(want.minutes));
                    if (out_if.seconds !== want.seconds)
                        report_mismatch("seconds", 16'(out_if.seconds), 16'(want.seconds));
                    if (out_if.colon_on !== want.colon_on)
                        report_mismatch("colon_on", 16'(out_if.colon_on),
                                        16'(want.colon_on));
                    if (out_if.set_mode !== want.set_mode)
                        report_mismatch("set_mode", 16'(out_if.set_mode),
                                        16'(want.set_mode));
                    if (out_if.hours_blink !== want.hours_blink)
                        report_mismatch("hours_blink", 16'(out_if.hours_blink),
                                        16'(want.hours_blink));
                    if (out_if.minutes_blink !== want.minutes_blink)
                        report_mismatch("minutes_blink", 16'(out_if.minutes_blink),
                                        16'(want.minutes_blink));
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                out_stall = idle_len(out_quiet);
            end
        end
    end

    // Watchdog: work outstanding but no transaction on either side for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else if (key_tick_q.size() != 0 || in_if.valid || expected_display_q.size() != 0)
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial begin
        logic [15:0] hp_plan[6];
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = 16'd0;
        in_if.valid     = 1'b0;
        in_if.key_event = KEY_NONE;
        in_if.tick_now  = 16'd0;
        out_if.ready    = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset half period, tick wrap, keys in every mode, saturation at zero
        push_item(KEY_NONE,  16'd0);
        push_item(KEY_NONE,  16'd499);
        push_item(KEY_NONE,  16'd500);
        push_item(KEY_PLUS,  16'd1000);
        push_item(KEY_MINUS, 16'hFFFF);
        push_item(KEY_NONE,  16'd498);
        push_item(KEY_NONE,  16'd499);
        push_item(KEY_LONG,  16'hFFFF);
        push_item(KEY_MINUS, 16'd0);
        push_item(KEY_PLUS,  16'hAAAA);
        push_item(KEY_NONE,  16'h5555);
        push_item(KEY_LONG,  16'd0);
        push_item(KEY_MINUS, 16'hFFFF);
        push_item(KEY_PLUS,  16'h5555);
        push_item(KEY_PLUS,  16'hAAAA);
        push_item(KEY_NONE,  16'd0);
        push_item(KEY_LONG,  16'h5555);
        push_item(KEY_NONE,  16'd999);
        push_item(KEY_PLUS,  16'd1000);
        tick_cursor = 16'd1000;

        // Half period settings, extremes included
        hp_plan[0] = 16'd1;
        hp_plan[1] = 16'd0;
        hp_plan[2] = 16'hFFFF;
        hp_plan[3] = 16'd7;
        hp_plan[4] = HALF_PERIOD_RESET;
        hp_plan[5] = 16'($urandom_range(2, 65534));
        for (int i = 0; i < 6; i++) begin
            write_half_period(hp_plan[i]);
            if (i == 0 || i == 2) push_rollover(hp_plan[i]);
            gen_traffic(110, hp_plan[i]);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
